// ===== sv/csc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants of the counter-mode stream cipher
// Widths, state encodings and the control/status bundles between the top
// level and the keystream generator.
// ----------------------------------------------------------------------------
package csc_pkg;

    // block geometry
    localparam int BLOCK_BYTES_DEF = 16;
    localparam int MIX_ROUNDS_DEF  = 6;
    localparam int MAX_BLOCK       = 16;
    localparam int POS_W           = 4;
    localparam int KEY_W           = 8 * MAX_BLOCK;
    localparam int CTR_W           = 8 * MAX_BLOCK;
    localparam int KLEN_W          = 5;

    // ports
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 136;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW,
        CFG_KEY_HIGH,
        CFG_KEY_LENGTH,
        CFG_IV_HIGH,
        CFG_IV_LOW,
        CFG_ENCRYPT_MODE
    } cfg_index_t;

    // top-level request sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_EMIT
    } ctl_state_t;

    // keystream generator sequencer
    typedef enum logic [1:0] {
        KG_IDLE,
        KG_LOAD,
        KG_MIX
    } kg_state_t;

    typedef struct packed {
        logic start;
        logic advance;
    } kg_ctrl_t;

    typedef struct packed {
        logic       done;
        logic [7:0] ks_byte;
    } kg_stat_t;

endpackage
`default_nettype wire

// ===== sv/csc_keygen.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_keygen: byte-serial keystream generator
// One shared byte mix unit steps over the keystream line once per cycle:
// a load pass (counter XOR key) followed by MIX_ROUNDS mix passes. The line
// is a rotating shift register; its head is the next keystream byte.
// ----------------------------------------------------------------------------
module csc_keygen #(
    parameter int BLOCK_BYTES = csc_pkg::BLOCK_BYTES_DEF,
    parameter int MIX_ROUNDS  = csc_pkg::MIX_ROUNDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  csc_pkg::kg_ctrl_t           ctrl,
    input  logic [csc_pkg::KEY_W-1:0]   key,
    input  logic [csc_pkg::KLEN_W-1:0]  key_len,
    input  logic [csc_pkg::CTR_W-1:0]   ctr,
    output csc_pkg::kg_stat_t           stat
);
    import csc_pkg::*;

    localparam int RND_W = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
    localparam logic [POS_W-1:0] LAST_STEP = POS_W'(BLOCK_BYTES - 1);
    localparam logic [RND_W-1:0] LAST_RND  = RND_W'(MIX_ROUNDS - 1);

    kg_state_t        state_reg, state_next;
    logic [POS_W-1:0] step_reg, step_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [POS_W-1:0] kidx_reg, kidx_next;
    logic [POS_W-1:0] rkidx_reg, rkidx_next;
    logic [7:0]       cs_reg, cs_next;
    logic [7:0]       ks_reg [BLOCK_BYTES];

    logic             shift_en;
    logic [7:0]       shift_in;
    logic             done;
    logic             last_step;
    logic [7:0]       kbyte;
    logic [7:0]       cbyte;
    logic [7:0]       load_v;
    logic [7:0]       mix_s;

    function automatic logic [7:0] rotl3(input logic [7:0] v);
        return {v[4:0], v[7:5]};
    endfunction

    function automatic logic [7:0] rotl1(input logic [7:0] v);
        return {v[6:0], v[7]};
    endfunction

    // advance a key index, wrapping at the key length
    function automatic logic [POS_W-1:0] key_wrap(input logic [POS_W-1:0] k,
                                                  input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] inc;
        inc = {1'b0, k} + KLEN_W'(1);
        return (inc == len) ? '0 : inc[POS_W-1:0];
    endfunction

    // operand selection: key byte by index, counter byte 0 in the top bits
    assign last_step = (step_reg == LAST_STEP);
    assign kbyte     = key[{kidx_reg, 3'b000} +: 8];
    assign cbyte     = ctr[{~step_reg, 3'b000} +: 8];
    assign load_v    = cbyte ^ kbyte;
    assign mix_s     = rotl3(ks_reg[0] ^ cs_reg) + kbyte;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            KG_IDLE: begin
                if (ctrl.start) begin
                    state_next = KG_LOAD;
                end
            end
            KG_LOAD: begin
                if (last_step) begin
                    state_next = KG_MIX;
                end
            end
            KG_MIX: begin
                if (last_step && (rnd_reg == LAST_RND)) begin
                    state_next = KG_IDLE;
                end
            end
            default: state_next = KG_IDLE;
        endcase
    end

    // step the shared mix unit
    always_comb begin
        step_next  = step_reg;
        rnd_next   = rnd_reg;
        kidx_next  = kidx_reg;
        rkidx_next = rkidx_reg;
        cs_next    = cs_reg;
        shift_en   = 1'b0;
        shift_in   = ks_reg[0];
        done       = 1'b0;
        unique case (state_reg)
            KG_IDLE: begin
                if (ctrl.start) begin
                    step_next  = '0;
                    rnd_next   = '0;
                    kidx_next  = '0;
                    rkidx_next = '0;
                    cs_next    = '0;
                end else if (ctrl.advance) begin
                    shift_en = 1'b1;
                end
            end
            KG_LOAD: begin
                shift_en  = 1'b1;
                shift_in  = load_v;
                cs_next   = cs_reg ^ load_v;
                step_next = step_reg + POS_W'(1);
                kidx_next = key_wrap(kidx_reg, key_len);
                if (last_step) begin
                    step_next = '0;
                    kidx_next = '0;
                end
            end
            KG_MIX: begin
                shift_en  = 1'b1;
                shift_in  = mix_s;
                cs_next   = rotl1(cs_reg ^ mix_s);
                step_next = step_reg + POS_W'(1);
                kidx_next = key_wrap(kidx_reg, key_len);
                if (last_step) begin
                    step_next  = '0;
                    rkidx_next = key_wrap(rkidx_reg, key_len);
                    kidx_next  = key_wrap(rkidx_reg, key_len);
                    rnd_next   = rnd_reg + RND_W'(1);
                    done       = (rnd_reg == LAST_RND);
                end
            end
            default: begin
                step_next = '0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KG_IDLE;
            step_reg  <= '0;
            rnd_reg   <= '0;
            kidx_reg  <= '0;
            rkidx_reg <= '0;
            cs_reg    <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rnd_reg   <= rnd_next;
            kidx_reg  <= kidx_next;
            rkidx_reg <= rkidx_next;
            cs_reg    <= cs_next;
        end
    end

    // rotate the keystream line
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int j = 0; j < BLOCK_BYTES - 1; j++) begin
                ks_reg[j] <= ks_reg[j+1];
            end
            ks_reg[BLOCK_BYTES-1] <= shift_in;
        end
    end

    assign stat.done    = done;
    assign stat.ks_byte = ks_reg[0];

endmodule
`default_nettype wire

// ===== sv/ctr_stream_cipher_with_xor_tag.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctr_stream_cipher_with_xor_tag: counter-mode byte stream cipher with tag
// Encrypts or decrypts one byte per request and folds a positional XOR tag.
// ----------------------------------------------------------------------------
// One byte request is taken at a time. A byte at the start of a block or of
// a message first waits for the byte-serial keystream generator, which handles
// one key byte per cycle through one load pass and MIX_ROUNDS mix passes.
// Every byte is accepted, then emitted into the output register. A request is
// accepted while an earlier result still waits in the output register. The tag
// fields read as zero except on the result for the last byte, flagged by
// m_tuser. Configuration must be written only between requests; the block does
// not enforce this. The IV is picked up at a message start.
module ctr_stream_cipher_with_xor_tag #(
    parameter int BLOCK_BYTES = csc_pkg::BLOCK_BYTES_DEF,
    parameter int MIX_ROUNDS  = csc_pkg::MIX_ROUNDS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [csc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [csc_pkg::S_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [csc_pkg::M_DATA_W-1:0]    m_tdata,   // [7:0] out_byte,
                                                       // [71:8] tag_high,
                                                       // [135:72] tag_low
    output logic                            m_tuser    // tag_valid
);
    import csc_pkg::*;

    localparam int CNT_W = 8 * BLOCK_BYTES;
    localparam logic [POS_W:0]    BLOCK_LEN   = (POS_W+1)'(BLOCK_BYTES);
    localparam logic [KLEN_W-1:0] KEY_LEN_MAX = KLEN_W'(MAX_BLOCK);

    // configuration registers
    logic [63:0]       key_low_reg;
    logic [63:0]       key_high_reg;
    logic [KLEN_W-1:0] key_len_reg;
    logic [63:0]       iv_high_reg;
    logic [63:0]       iv_low_reg;
    logic              enc_reg;

    // request state
    ctl_state_t        state_reg, state_next;
    logic [7:0]        data_reg;
    logic              last_reg;
    logic [CTR_W-1:0]  ctr_reg;
    logic [7:0]        tag_reg [MAX_BLOCK];
    logic [POS_W-1:0]  pos_reg;
    logic              msg_start_reg;

    // output register
    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic              m_user_reg;

    logic              in_fire;
    logic              out_free;
    logic              emit_fire;
    logic              need_ks;
    logic              block_end;
    logic [KLEN_W-1:0] key_len_eff;
    logic [7:0]        out_byte;
    logic [7:0]        tag_in;
    logic [7:0]        tag_upd [MAX_BLOCK];
    logic [63:0]       tag_high;
    logic [63:0]       tag_low;
    logic [CTR_W-1:0]  ctr_inc;
    kg_ctrl_t          kg_ctrl;
    kg_stat_t          kg_stat;

    // keystream generator
    csc_keygen #(
        .BLOCK_BYTES (BLOCK_BYTES),
        .MIX_ROUNDS  (MIX_ROUNDS)
    ) u_keygen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (kg_ctrl),
        .key     ({key_high_reg, key_low_reg}),
        .key_len (key_len_eff),
        .ctr     (ctr_reg),
        .stat    (kg_stat)
    );

    // out-of-range key lengths act as a full-length key
    assign key_len_eff = ((key_len_reg == '0) || (key_len_reg > KEY_LEN_MAX))
                         ? KEY_LEN_MAX : key_len_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign need_ks   = msg_start_reg || (pos_reg == '0);
    assign block_end = (({1'b0, pos_reg} + (POS_W+1)'(1)) >= BLOCK_LEN) || last_reg;

    // data path for the byte being emitted
    assign out_byte = data_reg ^ kg_stat.ks_byte;
    assign tag_in   = enc_reg ? out_byte : data_reg;

    always_comb begin
        for (int k = 0; k < MAX_BLOCK; k++) begin
            tag_upd[k] = tag_reg[k] ^ ((pos_reg == POS_W'(k)) ? tag_in : 8'h00);
        end
        for (int k = 0; k < 8; k++) begin
            tag_high[8*(7-k) +: 8] = tag_upd[k];
            tag_low[8*(7-k) +: 8]  = tag_upd[k+8];
        end
    end

    // big-endian increment over the bytes in use
    always_comb begin
        ctr_inc = ctr_reg;
        ctr_inc[CTR_W-1 -: CNT_W] = ctr_reg[CTR_W-1 -: CNT_W] + CNT_W'(1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = need_ks ? ST_KEYGEN : ST_EMIT;
                end
            end
            ST_KEYGEN: begin
                if (kg_stat.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready        = 1'b0;
        emit_fire       = 1'b0;
        kg_ctrl.start   = 1'b0;
        kg_ctrl.advance = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                kg_ctrl.start = s_tvalid && need_ks;
            end
            ST_KEYGEN: begin
                s_tready = 1'b0;
            end
            ST_EMIT: begin
                emit_fire       = out_free;
                kg_ctrl.advance = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_MAX;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            enc_reg      <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_KEY_LOW:      key_low_reg  <= cfg_data;
                CFG_KEY_HIGH:     key_high_reg <= cfg_data;
                CFG_KEY_LENGTH:   key_len_reg  <= cfg_data[KLEN_W-1:0];
                CFG_IV_HIGH:      iv_high_reg  <= cfg_data;
                CFG_IV_LOW:       iv_low_reg   <= cfg_data;
                CFG_ENCRYPT_MODE: enc_reg      <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            msg_start_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire && msg_start_reg) begin
                pos_reg       <= '0;
                msg_start_reg <= 1'b0;
            end
            if (emit_fire) begin
                pos_reg     <= block_end ? '0 : pos_reg + POS_W'(1);
                m_valid_reg <= 1'b1;
                if (last_reg) begin
                    msg_start_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload: request byte, counter, tag and result
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
            if (msg_start_reg) begin
                ctr_reg <= {iv_high_reg, iv_low_reg};
                for (int k = 0; k < MAX_BLOCK; k++) begin
                    tag_reg[k] <= 8'h00;
                end
            end
        end
        if (emit_fire) begin
            for (int k = 0; k < MAX_BLOCK; k++) begin
                tag_reg[k] <= tag_upd[k];
            end
            if (block_end) begin
                ctr_reg <= ctr_inc;
            end
            m_data_reg <= last_reg ? {tag_low, tag_high, out_byte}
                                   : {128'h0, out_byte};
            m_user_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

// ===== sv/csc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_checker: port-level checks of the stream cipher
// Watches the top-level ports and flags handshake and result-format slips.
// ----------------------------------------------------------------------------
module csc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csc_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                           m_tuser
);
    import csc_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // tag fields read zero unless flagged
    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[M_DATA_W-1:8] == '0)
        else $error("tag bits set without tag flag");

    // one request at a time: drop ready after an accept
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // a new result is loaded only while no request can be taken
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while input side was idle");

endmodule

bind ctr_stream_cipher_with_xor_tag csc_checker u_csc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
